// ----- design/fgpl_pkg.sv -----
// Shared types, widths and codes of the functional graph path length core.
`timescale 1ns / 1ps

package fgpl_pkg;

   localparam int IDX_W   = 12;  // node index width
   localparam int LEN_W   = 13;  // path length width
   localparam int STAMP_W = 12;  // walk stamp width
   localparam int ADDR_W  = 20;  // widest node memory address
   localparam int LIM_W   = 21;  // width for node limit compares

   localparam logic [LEN_W-1:0] LEN_MAX  = 13'h1FFF;
   localparam logic [LEN_W-1:0] IDX_SPAN = 13'd4096;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic REG_END_COUNT = 1'b0;

   typedef struct packed {
      logic [1:0]       func;
      logic [IDX_W-1:0] node_index;
      logic [IDX_W-1:0] next_index;
      logic             has_next;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] path_length;
      logic             error;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] target;
   } succ_entry_type;

   typedef struct packed {
      logic [LEN_W-1:0]   memo;
      logic [STAMP_W-1:0] stamp;
   } walk_entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              s_we;
      logic [ADDR_W-1:0] s_addr;
      succ_entry_type    s_data;
      logic              m_we;
      logic [ADDR_W-1:0] m_addr;
      walk_entry_type    m_data;
   } store_cmd_type;

   typedef struct packed {
      succ_entry_type s_ent;
      walk_entry_type m_ent;
   } store_rd_type;

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W:0] v);
      sat_len = v[LEN_W] ? LEN_MAX : v[LEN_W-1:0];
   endfunction

endpackage

// ----- design/fgpl_store.sv -----
// Node memories: successor table and length memo with walk stamps.
`timescale 1ns / 1ps

module fgpl_store import fgpl_pkg::*; #(
   parameter int MAX_NODES = 4096
) (
   input  logic          clock,
   input  store_cmd_type cmd,
   output store_rd_type  rd
);

   localparam int AW = $clog2(MAX_NODES);

   succ_entry_type succ_mem [MAX_NODES];
   walk_entry_type walk_mem [MAX_NODES];
   store_rd_type   rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.s_we) begin
         succ_mem[cmd.s_addr[AW-1:0]] <= cmd.s_data;
      end
      if (cmd.m_we) begin
         walk_mem[cmd.m_addr[AW-1:0]] <= cmd.m_data;
      end
      if (cmd.rd_en) begin
         rd_ff.s_ent <= succ_mem[cmd.rd_addr[AW-1:0]];
         rd_ff.m_ent <= walk_mem[cmd.rd_addr[AW-1:0]];
      end
   end

   assign rd = rd_ff;

endmodule

// ----- design/fgpl_ctrl.sv -----
// Item sequencer: loads, memory sweeps, chain walk and write-back passes.
`timescale 1ns / 1ps

module fgpl_ctrl import fgpl_pkg::*; #(
   parameter int MAX_NODES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req_data,
   output logic             busy,
   input  logic [LEN_W-1:0] end_count,
   output store_cmd_type    cmd,
   input  store_rd_type     rd,
   output logic             rsp_strobe,
   output rsp_type          rsp_data
);

   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_NODES);
   localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(MAX_NODES);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_RD    = 4'b0100,
      ST_EV    = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      PH_CHECK = 4'b0001,
      PH_WALK  = 4'b0010,
      PH_CYC   = 4'b0100,
      PH_PRE   = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      RET_NONE = 2'd0,
      RET_RESP = 2'd1,
      RET_WALK = 2'd2
   } ret_type;

   typedef struct packed {
      logic memo;
      logic stamp;
      logic valid;
   } sweep_mode_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   ret_type          ret_ff, ret_in;
   sweep_mode_type   mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [STAMP_W-1:0] qc_ff, qc_in;
   logic [IDX_W-1:0] q_ff, q_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] anchor_ff, anchor_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] clen_ff, clen_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W:0]   val_ff, val_in;
   logic [LEN_W-1:0] result_ff, result_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [LIM_W-1:0] limit;
   logic             nx_ok;

   assign limit = (LIM_W'(end_count) > MAX_LIM) ? MAX_LIM : LIM_W'(end_count);
   assign nx_ok = rd.s_ent.valid && (LIM_W'(rd.s_ent.target) < limit);
   assign busy  = (state_ff != ST_IDLE);

   always_comb begin
      logic [LEN_W-1:0]   clen_w;
      logic [LEN_W:0]     total_w;
      logic [STAMP_W-1:0] qc_next;
      state_in      = state_ff;
      phase_in      = phase_ff;
      ret_in        = ret_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      qc_in         = qc_ff;
      q_in          = q_ff;
      cur_in        = cur_ff;
      anchor_in     = anchor_ff;
      len_in        = len_ff;
      clen_in       = clen_ff;
      rem_in        = rem_ff;
      val_in        = val_ff;
      result_in     = result_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      cmd           = '0;
      clen_w        = len_ff - rd.m_ent.memo + LEN_W'(1);
      total_w       = {1'b0, len_ff} + {1'b0, rd.m_ent.memo};
      qc_next       = qc_ff + STAMP_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.func)
                  FUNC_LOAD: begin
                     if (LIM_W'(req_data.node_index) < MAX_LIM) begin
                        cmd.s_we          = 1'b1;
                        cmd.s_addr        = ADDR_W'(req_data.node_index);
                        cmd.s_data.valid  = req_data.has_next;
                        cmd.s_data.target = req_data.next_index;
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  FUNC_QUERY: begin
                     if (LIM_W'(req_data.node_index) < limit) begin
                        q_in     = req_data.node_index;
                        cur_in   = req_data.node_index;
                        phase_in = PH_CHECK;
                        state_in = ST_RD;
                     end else begin
                        rsp_strobe_in     = 1'b1;
                        rsp_data_in.error = 1'b1;
                     end
                  end
                  FUNC_CLEAR: begin
                     mode_in  = '{memo: 1'b1, stamp: 1'b0, valid: 1'b0};
                     ret_in   = RET_RESP;
                     cnt_in   = '0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SWEEP: begin
            // read entry n while writing back entry n-1
            if (cnt_ff < SWEEP_END) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = ADDR_W'(cnt_ff);
            end
            if (cnt_ff != '0) begin
               cmd.m_we          = 1'b1;
               cmd.m_addr        = ADDR_W'(cnt_ff - CNT_W'(1));
               cmd.m_data.memo   = mode_ff.memo ? '0 : rd.m_ent.memo;
               cmd.m_data.stamp  = mode_ff.stamp ? '0 : rd.m_ent.stamp;
               cmd.s_we          = mode_ff.valid;
               cmd.s_addr        = ADDR_W'(cnt_ff - CNT_W'(1));
               cmd.s_data.valid  = 1'b0;
               cmd.s_data.target = rd.s_ent.target;
            end
            if (cnt_ff == SWEEP_END) begin
               case (ret_ff)
                  RET_RESP: begin
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
                  RET_WALK: begin
                     cur_in   = q_ff;
                     phase_in = PH_WALK;
                     state_in = ST_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         ST_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ADDR_W'(cur_ff);
            state_in    = ST_EV;
         end

         ST_EV: begin
            state_in = ST_RD;
            case (phase_ff)
               PH_CHECK: begin
                  len_in = '0;
                  if (rd.m_ent.memo != '0) begin
                     rsp_strobe_in           = 1'b1;
                     rsp_data_in.path_length = rd.m_ent.memo;
                     state_in                = ST_IDLE;
                  end else if (qc_next == '0) begin
                     qc_in    = STAMP_W'(1);
                     mode_in  = '{memo: 1'b0, stamp: 1'b1, valid: 1'b0};
                     ret_in   = RET_WALK;
                     cnt_in   = '0;
                     state_in = ST_SWEEP;
                  end else begin
                     qc_in    = qc_next;
                     phase_in = PH_WALK;
                  end
               end

               PH_WALK: begin
                  if (rd.m_ent.memo != '0) begin
                     cur_in = q_ff;
                     if (rd.m_ent.stamp == qc_ff) begin
                        // reached a node of this walk: cycle
                        clen_in   = clen_w;
                        anchor_in = cur_ff;
                        rem_in    = rd.m_ent.memo - LEN_W'(1);
                        val_in    = {1'b0, len_ff};
                        result_in = (rd.m_ent.memo == LEN_W'(1)) ? clen_w
                                                                  : len_ff;
                        cur_in    = cur_ff;
                        phase_in  = PH_CYC;
                     end else begin
                        // joined a chain of known length
                        rem_in    = len_ff;
                        val_in    = total_w;
                        result_in = sat_len(total_w);
                        phase_in  = PH_PRE;
                     end
                  end else begin
                     cmd.m_we         = 1'b1;
                     cmd.m_addr       = ADDR_W'(cur_ff);
                     cmd.m_data.memo  = len_ff + LEN_W'(1);
                     cmd.m_data.stamp = qc_ff;
                     len_in           = len_ff + LEN_W'(1);
                     if (nx_ok) begin
                        cur_in = rd.s_ent.target;
                     end else begin
                        cur_in    = q_ff;
                        rem_in    = len_ff + LEN_W'(1);
                        val_in    = {1'b0, len_ff + LEN_W'(1)};
                        result_in = len_ff + LEN_W'(1);
                        phase_in  = PH_PRE;
                     end
                  end
               end

               PH_CYC: begin
                  cmd.m_we         = 1'b1;
                  cmd.m_addr       = ADDR_W'(cur_ff);
                  cmd.m_data.memo  = clen_ff;
                  cmd.m_data.stamp = rd.m_ent.stamp;
                  if (nx_ok && (rd.s_ent.target != anchor_ff)) begin
                     cur_in = rd.s_ent.target;
                  end else if (rem_ff == '0) begin
                     rsp_strobe_in           = 1'b1;
                     rsp_data_in.path_length = result_ff;
                     state_in                = ST_IDLE;
                  end else begin
                     cur_in   = q_ff;
                     phase_in = PH_PRE;
                  end
               end

               PH_PRE: begin
                  cmd.m_we         = 1'b1;
                  cmd.m_addr       = ADDR_W'(cur_ff);
                  cmd.m_data.memo  = sat_len(val_ff);
                  cmd.m_data.stamp = rd.m_ent.stamp;
                  val_in           = val_ff - (LEN_W+1)'(1);
                  rem_in           = rem_ff - LEN_W'(1);
                  if (nx_ok && (rem_ff != LEN_W'(1))) begin
                     cur_in = rd.s_ent.target;
                  end else begin
                     rsp_strobe_in           = 1'b1;
                     rsp_data_in.path_length = result_ff;
                     state_in                = ST_IDLE;
                  end
               end

               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         phase_ff      <= PH_CHECK;
         ret_ff        <= RET_NONE;
         mode_ff       <= '{memo: 1'b1, stamp: 1'b1, valid: 1'b1};
         cnt_ff        <= '0;
         qc_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         ret_ff        <= ret_in;
         mode_ff       <= mode_in;
         cnt_ff        <= cnt_in;
         qc_ff         <= qc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      cur_ff      <= cur_in;
      anchor_ff   <= anchor_in;
      len_ff      <= len_in;
      clen_ff     <= clen_in;
      rem_ff      <= rem_in;
      val_ff      <= val_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (cnt_ff <= SWEEP_END))
      else $error("sweep counter ran past the last entry");

   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.m_we && cmd.rd_en) |-> (cmd.m_addr != cmd.rd_addr))
      else $error("write-back and read hit the same entry in one cycle");

   a_live_stamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV && phase_ff != PH_CHECK) |-> (qc_ff != '0))
      else $error("walk running with the reserved stamp");

   // len is only meaningful once the check step has cleared it
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV && phase_ff != PH_CHECK) |-> (len_ff <= IDX_SPAN))
      else $error("walk length exceeds the node span");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == ST_IDLE))
      else $error("result issued while still working");

endmodule

// ----- design/functional_graph_path_length_core.sv -----
// Top level: register port, node memories and item sequencer.
`timescale 1ns / 1ps

// Memoized path length engine over a functional graph.
// Items are offered on req_data with start and taken at an edge where start
// is high and busy is low. Every item gives one result on rsp_data, held for
// one cycle and marked by rsp_strobe; the receiver cannot stall, so results
// are never held back. Load, out-of-range query and unused codes answer in
// the cycle after the transfer and leave busy low (one item per cycle).
// A query with a cached length answers after a single read of its node entry.
// A walking query makes each node access through the single read port of the
// node memories (read, then write-back), over the walk, cycle and prefix
// nodes, and runs a stamp-clearing sweep first when the walk stamp wraps.
// A clear item sweeps the memo over all node entries.
// After reset the block runs a clearing pass over all node entries with busy
// high; register writes are taken throughout.
// Register end_count sits at byte address 0; change it only while idle.

module functional_graph_path_length_core import fgpl_pkg::*; #(
   parameter int MAX_NODES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req_data,
   output logic        busy,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [LEN_W-1:0] end_count_ff, end_count_in;
   store_cmd_type    cmd;
   store_rd_type     rd;

   // register write completes on the access phase
   always_comb begin
      end_count_in = end_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr[2] == REG_END_COUNT)) begin
         end_count_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_count_ff <= IDX_SPAN;
      end else begin
         end_count_ff <= end_count_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_END_COUNT) ? 32'(end_count_ff) : 32'd0;

   fgpl_store #(.MAX_NODES(MAX_NODES)) u_store (
      .clock (clock),
      .cmd   (cmd),
      .rd    (rd)
   );

   fgpl_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .end_count  (end_count_ff),
      .cmd        (cmd),
      .rd         (rd),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- verif/fgpl_checker.sv -----
// Checker: predicts path length results from observed transfers and compares them.
`timescale 1ns / 1ps

module fgpl_checker import fgpl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_strobe,
   input  rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);

   localparam int NODES = 4096;

   logic [IDX_W-1:0]   succ_target [NODES];
   bit                 succ_valid  [NODES];
   logic [LEN_W-1:0]   len_memo    [NODES];
   logic [STAMP_W-1:0] walk_tag    [NODES];
   logic [STAMP_W-1:0] walk_count;
   logic [LEN_W-1:0]   end_count;
   rsp_type            expected_rsp [$];

   function automatic int node_limit();
      return (end_count > NODES) ? NODES : int'(end_count);
   endfunction

   function automatic bit next_node(input int n, output int nx);
      if (!succ_valid[n]) return 0;
      if (int'(succ_target[n]) >= node_limit()) return 0;
      nx = succ_target[n];
      return 1;
   endfunction

   function automatic logic [LEN_W-1:0] sat(input int v);
      return (v > int'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
   endfunction

   // memoized walk: first pass tags positions, cycle pass, prefix rewrite
   function automatic logic [LEN_W-1:0] query_length(input int q);
      int cur, len, total, prefix, nx, pos, c, steps, i;
      bit at_end;
      logic [LEN_W-1:0] clen;
      cur = q;
      len = 0;
      at_end = 0;
      nx = 0;
      if (len_memo[q] != 0) return len_memo[q];
      walk_count = walk_count + 1'b1;
      if (walk_count == 0) begin
         foreach (walk_tag[k]) walk_tag[k] = '0;
         walk_count = 1;
      end
      forever begin
         if (len_memo[cur] != 0) break;
         walk_tag[cur] = walk_count;
         len++;
         len_memo[cur] = sat(len);
         if (!next_node(cur, nx)) begin
            at_end = 1;
            break;
         end
         cur = nx;
      end
      if (at_end) begin
         total = len;
         prefix = len;
      end else if (walk_tag[cur] == walk_count) begin
         pos = len_memo[cur];
         clen = sat(len - pos + 1);
         c = cur;
         steps = 0;
         do begin
            len_memo[c] = clen;
            if (!next_node(c, nx)) break;
            c = nx;
            steps++;
         end while (c != cur && steps < NODES);
         total = len;
         prefix = pos - 1;
      end else begin
         total = len + len_memo[cur];
         prefix = len;
      end
      cur = q;
      for (i = 0; i < prefix; i++) begin
         len_memo[cur] = sat(total - i);
         if (!next_node(cur, nx)) break;
         cur = nx;
      end
      return len_memo[q];
   endfunction

   function automatic rsp_type predict_rsp(input req_type r);
      rsp_type o;
      o = '0;
      case (r.func)
         FUNC_LOAD: begin
            succ_target[r.node_index] = r.next_index;
            succ_valid[r.node_index]  = r.has_next;
         end
         FUNC_QUERY: begin
            if (int'(r.node_index) >= node_limit()) o.error = 1'b1;
            else o.path_length = query_length(r.node_index);
         end
         FUNC_CLEAR: foreach (len_memo[k]) len_memo[k] = '0;
         default: ;
      endcase
      return o;
   endfunction

   task automatic report(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      walk_count = '0;
      end_count = IDX_SPAN;
      foreach (succ_target[k]) begin
         succ_target[k] = '0;
         succ_valid[k]  = 0;
         len_memo[k]    = '0;
         walk_tag[k]    = '0;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) report("result with nothing expected");
            else begin
               e = expected_rsp.pop_front();
               if (rsp_data.path_length !== e.path_length)
                  report($sformatf("path_length %0d, expected %0d",
                                   rsp_data.path_length, e.path_length));
               if (rsp_data.error !== e.error)
                  report($sformatf("error %0b, expected %0b", rsp_data.error, e.error));
            end
         end
         if (start && !busy) expected_rsp.push_back(predict_rsp(req_data));
      end
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 3'd0)
         end_count = csr_pwdata[LEN_W-1:0];
      pending = expected_rsp.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top: clock, reset, stimulus and verdict for the path length core.
`timescale 1ns / 1ps

module tb_top;
   import fgpl_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   req_type     req_data;
   logic        busy;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;

   bit          idle_on;      // random gaps between transfers
   int          node_span;    // node range of the current random phase

   functional_graph_path_length_core dut (.*);

   fgpl_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #40ms;
      $display("tb_top NOT OK");
      $finish;
   end

   // one transfer; start stays high if the next item follows without a gap
   task automatic send_item(input logic [1:0] f, input int node, input int nxt,
                            input bit hn);
      req_type r;
      r.func = f;
      r.node_index = node[IDX_W-1:0];
      r.next_index = nxt[IDX_W-1:0];
      r.has_next = hn;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic load(input int node, input int nxt, input bit hn);
      send_item(FUNC_LOAD, node, nxt, hn);
   endtask

   task automatic query(input int node);
      send_item(FUNC_QUERY, node, $urandom, 1'($urandom));
   endtask

   // register writes only once the core is drained and idle
   task automatic write_end_count(input int v);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'd0;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_node();
      // mostly a narrow window so chains link up; sometimes anywhere
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                         : $urandom_range(0, node_span - 1);
   endfunction

   task automatic random_item();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 42) load(pick_node(), pick_node(), $urandom_range(0, 7) != 0);
      else if (sel < 94) query(pick_node());
      else if (sel < 96) send_item(FUNC_CLEAR, $urandom, $urandom, 1'($urandom));
      else if (sel < 98) send_item(FUNC_UNUSED, $urandom, $urandom, 1'($urandom));
      else send_item(2'($urandom), $urandom, $urandom, 1'($urandom));   // raw noise
   endtask

   initial begin
      int settings [6] = '{32, 1, 0, 8191, 200, 4096};
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_on = 1'b1;
      node_span = 64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: straight chain, cached hit, cycle, tail into a cycle
      load(0, 1, 1); load(1, 2, 1); load(2, 0, 0);
      query(0); query(0); query(2);
      load(3, 4, 1); load(4, 5, 1); load(5, 3, 1);
      query(4);
      load(6, 3, 1); query(6);
      load(8, 8, 1); query(8);                      // self loop
      load(4095, 0, 1); query(4095);                // top node joins known chain
      send_item(FUNC_UNUSED, 4095, 4095, 1);
      send_item(FUNC_CLEAR, 0, 0, 0);
      query(4095);

      // successor beyond end_count ends the chain; loads beyond it still land
      write_end_count(32);
      load(9, 100, 1); query(9);
      load(40, 1, 1); query(40);
      write_end_count(0);
      query(0);                                     // everything is an error
      write_end_count(4096);
      query(40);

      // random phases over several end_count settings
      foreach (settings[s]) begin
         write_end_count(settings[s]);
         node_span = (s % 2) ? 16 : 64;
         idle_on = (s != 1);
         repeat (230) random_item();
      end

      // remaining random items, the tail with no idling at all
      idle_on = 1'b1;
      node_span = 48;
      repeat (345) random_item();
      idle_on = 1'b0;
      repeat (100) random_item();

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
